>>> sv/qmlm_pkg.sv
// Shared types, constants and sign tables for the quadrotor motor lag mixer.
// Used by qmlm_lane, qmlm_mix and quadrotor_motor_lag_mixer; depends on nothing.
`default_nettype none
package qmlm_pkg;

   localparam int ROTOR_COUNT_DEF = 4;

   // Field widths.
   localparam int MODE_W   = 2;
   localparam int SPEED_W  = 18;
   localparam int GAIN_W   = 16;
   localparam int COEFF_W  = 20;
   localparam int AGE_W    = 16;
   localparam int THRUST_W = 22;
   localparam int TORQUE_W = 19;
   localparam int YAW_W    = 16;
   localparam int FORCE_W  = 24;   // one rotor thrust, Q.16
   localparam int COMBO_W  = 27;   // signed sum of four rotor thrusts
   localparam int PROD_W   = 44;   // gain times combination

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [SPEED_W-1:0]  SPEED_MAX  = SPEED_W'(230400);
   localparam logic [THRUST_W-1:0] THRUST_MAX = {THRUST_W{1'b1}};
   localparam logic [AGE_W-1:0]    AGE_MAX    = {AGE_W{1'b1}};

   localparam logic [GAIN_W-1:0]  LAG_GAIN_RST     = GAIN_W'(2570);
   localparam logic [AGE_W-1:0]   TIMEOUT_RST      = AGE_W'(250);
   localparam logic [COEFF_W-1:0] THRUST_COEFF_RST = COEFF_W'(42950);
   localparam logic [GAIN_W-1:0]  ARM_GAIN_RST     = GAIN_W'(13107);
   localparam logic [GAIN_W-1:0]  YAW_GAIN_RST     = GAIN_W'(1311);

   // Item kinds.
   localparam logic [MODE_W-1:0] MODE_CMD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LAG_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRUST_COEFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_GAIN     = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAG,
      ST_SPEED,
      ST_SQUARE,
      ST_PROD_LO,
      ST_PROD_HI,
      ST_THRUST,
      ST_MIX,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_cmd;
      logic clear;
      logic fresh;
      logic lag_en;
      logic speed_en;
      logic square_en;
      logic lo_en;
      logic hi_en;
      logic thrust_en;
   } lane_ctl_type;

   typedef struct packed {
      logic mix_en;
      logic scale_en;
   } mix_ctl_type;

   // Rotor layout: roll is f0 - f1 - f2 + f3, pitch f0 + f1 - f2 - f3,
   // yaw -f0 + f1 - f2 + f3.
   function automatic logic roll_neg(input logic [1:0] idx);
      logic neg;
      case (idx) inside
         2'd1, 2'd2: neg = 1'b1;
         default:    neg = 1'b0;
      endcase
      return neg;
   endfunction

   function automatic logic pitch_neg(input logic [1:0] idx);
      logic neg;
      case (idx) inside
         2'd2, 2'd3: neg = 1'b1;
         default:    neg = 1'b0;
      endcase
      return neg;
   endfunction

   function automatic logic yaw_neg(input logic [1:0] idx);
      logic neg;
      case (idx) inside
         2'd0, 2'd2: neg = 1'b1;
         default:    neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage
`default_nettype wire

>>> sv/qmlm_lane.sv
// One rotor lane: requested and lagged speed, then the squared speed scaled
// into a thrust over several registered multiply steps. Uses qmlm_pkg.
`default_nettype none
module qmlm_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire qmlm_pkg::lane_ctl_type        ctl,
   input  wire logic [qmlm_pkg::SPEED_W-1:0]  cmd_speed,
   input  wire logic [qmlm_pkg::GAIN_W-1:0]   lag_gain,
   input  wire logic [qmlm_pkg::COEFF_W-1:0]  thrust_coeff,
   output logic      [qmlm_pkg::SPEED_W-1:0]  speed,
   output logic      [qmlm_pkg::FORCE_W-1:0]  thrust
);
   localparam int SW  = qmlm_pkg::SPEED_W;
   localparam int DW  = SW + 1;                       // signed difference
   localparam int LW  = qmlm_pkg::GAIN_W + DW;        // lag product
   localparam int QW  = 2 * SW;                       // squared speed
   localparam int HW  = SW + qmlm_pkg::COEFF_W;       // half product
   localparam int FW  = qmlm_pkg::FORCE_W;

   logic [SW-1:0]        req_ff, req_in;
   logic [SW-1:0]        speed_ff, speed_in;
   logic signed [LW-1:0] lag_ff, lag_in;
   logic [QW-1:0]        sq_ff, sq_in;
   logic [HW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [FW-1:0]        thrust_ff, thrust_in;

   logic [SW-1:0]        target;
   logic signed [DW-1:0] diff;
   logic signed [LW-1:0] gain_ext, diff_ext;
   logic signed [DW-1:0] step;
   logic signed [SW+1:0] sum_s;
   logic [HW:0]          half_sum;

   always_comb begin
      req_in = req_ff;
      if (ctl.clear) begin
         req_in = '0;
      end else if (ctl.load_cmd) begin
         req_in = (cmd_speed > qmlm_pkg::SPEED_MAX) ? qmlm_pkg::SPEED_MAX : cmd_speed;
      end
   end

   // Lag product, floor of gain times difference over 2^16 comes from its top bits.
   assign target   = ctl.fresh ? req_ff : '0;
   assign diff     = $signed({1'b0, target}) - $signed({1'b0, speed_ff});
   assign gain_ext = $signed({{(LW - qmlm_pkg::GAIN_W){1'b0}}, lag_gain});
   assign diff_ext = $signed({{(LW - DW){diff[DW-1]}}, diff});
   assign lag_in   = gain_ext * diff_ext;

   assign step  = lag_ff[LW-1:16];
   assign sum_s = $signed({2'b00, speed_ff}) + $signed({step[DW-1], step});

   always_comb begin
      speed_in = speed_ff;
      if (ctl.clear) begin
         speed_in = '0;
      end else if (ctl.speed_en) begin
         if (sum_s[SW+1]) begin
            speed_in = '0;
         end else if (sum_s[SW:0] > {1'b0, qmlm_pkg::SPEED_MAX}) begin
            speed_in = qmlm_pkg::SPEED_MAX;
         end else begin
            speed_in = sum_s[SW-1:0];
         end
      end
   end

   assign sq_in = {{SW{1'b0}}, speed_ff} * {{SW{1'b0}}, speed_ff};
   assign lo_in = {{qmlm_pkg::COEFF_W{1'b0}}, sq_ff[SW-1:0]}
                * {{SW{1'b0}}, thrust_coeff};
   assign hi_in = {{qmlm_pkg::COEFF_W{1'b0}}, sq_ff[QW-1:SW]}
                * {{SW{1'b0}}, thrust_coeff};

   // speed^2 * coeff >> 32 equals (hi + (lo >> 18)) >> 14 with no rounding loss.
   assign half_sum  = {1'b0, hi_ff} + {{(SW + 1){1'b0}}, lo_ff[HW-1:SW]};
   assign thrust_in = half_sum[FW+13:14];

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff   <= '0;
         speed_ff <= '0;
      end else begin
         req_ff   <= req_in;
         speed_ff <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.lag_en)    lag_ff    <= lag_in;
      if (ctl.square_en) sq_ff     <= sq_in;
      if (ctl.lo_en)     lo_ff     <= lo_in;
      if (ctl.hi_en)     hi_ff     <= hi_in;
      if (ctl.thrust_en) thrust_ff <= thrust_in;
   end

   assign speed  = speed_ff;
   assign thrust = thrust_ff;

   a_speed_in_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff <= qmlm_pkg::SPEED_MAX)
      else $error("rotor speed above its limit");

endmodule
`default_nettype wire

>>> sv/qmlm_mix.sv
// Merging stage: sums the lane thrusts into total thrust and roll, pitch and
// yaw combinations, scales them by the gains and saturates. Uses qmlm_pkg.
`default_nettype none
module qmlm_mix #(
   parameter int ROTOR_COUNT = qmlm_pkg::ROTOR_COUNT_DEF
) (
   input  wire logic                                           clock,
   input  wire qmlm_pkg::mix_ctl_type                          ctl,
   input  wire logic [ROTOR_COUNT-1:0][qmlm_pkg::FORCE_W-1:0]  thrust,
   input  wire logic [qmlm_pkg::GAIN_W-1:0]                    arm_gain,
   input  wire logic [qmlm_pkg::GAIN_W-1:0]                    yaw_gain,
   output logic      [qmlm_pkg::THRUST_W-1:0]                  thrust_total,
   output logic      [qmlm_pkg::TORQUE_W-1:0]                  roll_torque,
   output logic      [qmlm_pkg::TORQUE_W-1:0]                  pitch_torque,
   output logic      [qmlm_pkg::YAW_W-1:0]                     yaw_torque
);
   localparam int CW = qmlm_pkg::COMBO_W;
   localparam int PW = qmlm_pkg::PROD_W;
   localparam int SW = PW - 16;                 // scaled width after the shift
   localparam int TW = qmlm_pkg::TORQUE_W;
   localparam int YW = qmlm_pkg::YAW_W;

   logic [CW-1:0]        total_ff, total_in;
   logic signed [CW-1:0] roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [PW-1:0] roll_p_ff, roll_p_in, pitch_p_ff, pitch_p_in, yaw_p_ff, yaw_p_in;
   logic signed [PW-1:0] arm_ext, yaw_g_ext;
   logic signed [SW-1:0] roll_s, pitch_s, yaw_s;
   logic signed [CW-1:0] f_ext;

   always_comb begin
      total_in = '0;
      roll_in  = '0;
      pitch_in = '0;
      yaw_in   = '0;
      f_ext    = '0;
      for (int i = 0; i < ROTOR_COUNT; i++) begin
         f_ext    = $signed({{(CW - qmlm_pkg::FORCE_W){1'b0}}, thrust[i]});
         total_in = total_in + f_ext;
         roll_in  = qmlm_pkg::roll_neg(2'(i))  ? roll_in  - f_ext : roll_in  + f_ext;
         pitch_in = qmlm_pkg::pitch_neg(2'(i)) ? pitch_in - f_ext : pitch_in + f_ext;
         yaw_in   = qmlm_pkg::yaw_neg(2'(i))   ? yaw_in   - f_ext : yaw_in   + f_ext;
      end
   end

   assign arm_ext    = $signed({{(PW - qmlm_pkg::GAIN_W){1'b0}}, arm_gain});
   assign yaw_g_ext  = $signed({{(PW - qmlm_pkg::GAIN_W){1'b0}}, yaw_gain});
   assign roll_p_in  = arm_ext * $signed({{(PW - CW){roll_ff[CW-1]}}, roll_ff});
   assign pitch_p_in = arm_ext * $signed({{(PW - CW){pitch_ff[CW-1]}}, pitch_ff});
   assign yaw_p_in   = yaw_g_ext * $signed({{(PW - CW){yaw_ff[CW-1]}}, yaw_ff});

   always_ff @(posedge clock) begin
      if (ctl.mix_en) begin
         total_ff <= total_in;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
      if (ctl.scale_en) begin
         roll_p_ff  <= roll_p_in;
         pitch_p_ff <= pitch_p_in;
         yaw_p_ff   <= yaw_p_in;
      end
   end

   // An arithmetic shift of the product is the floor division by 2^16.
   assign roll_s  = roll_p_ff[PW-1:16];
   assign pitch_s = pitch_p_ff[PW-1:16];
   assign yaw_s   = yaw_p_ff[PW-1:16];

   function automatic logic [TW-1:0] sat_torque(input logic signed [SW-1:0] v);
      logic [TW-1:0] r;
      if (v < -$signed(SW'(1) <<< (TW - 1))) begin
         r = {1'b1, {(TW - 1){1'b0}}};
      end else if (v > $signed((SW'(1) <<< (TW - 1)) - SW'(1))) begin
         r = {1'b0, {(TW - 1){1'b1}}};
      end else begin
         r = v[TW-1:0];
      end
      return r;
   endfunction

   function automatic logic [YW-1:0] sat_yaw(input logic signed [SW-1:0] v);
      logic [YW-1:0] r;
      if (v < -$signed(SW'(1) <<< (YW - 1))) begin
         r = {1'b1, {(YW - 1){1'b0}}};
      end else if (v > $signed((SW'(1) <<< (YW - 1)) - SW'(1))) begin
         r = {1'b0, {(YW - 1){1'b1}}};
      end else begin
         r = v[YW-1:0];
      end
      return r;
   endfunction

   assign thrust_total = (total_ff > CW'(qmlm_pkg::THRUST_MAX)) ?
                         qmlm_pkg::THRUST_MAX : total_ff[qmlm_pkg::THRUST_W-1:0];
   assign roll_torque  = sat_torque(roll_s);
   assign pitch_torque = sat_torque(pitch_s);
   assign yaw_torque   = sat_yaw(yaw_s);

endmodule
`default_nettype wire

>>> sv/quadrotor_motor_lag_mixer.sv
// Four-rotor motor lag and thrust/torque mixer. A command item (tuser 0) takes
// four requested speeds, a reset item (tuser 2) clears rotor state, and a tick
// item (tuser 1) ages the command, lags each rotor speed and returns total thrust,
// roll, pitch and yaw torques with the new speeds. Command, reset and unused items
// are taken while idle and give no result. A tick passes through registered steps
// to a valid result: each rotor lane runs its lag multiply, speed update, squaring,
// the two halves of the thrust multiply and the thrust sum one register apart, and
// the merging stage then sums and scales, and the result is saturated as it is
// registered. The next item is taken the cycle after the result is registered,
// even while that result still waits. Depends on qmlm_pkg, qmlm_lane and qmlm_mix.
`default_nettype none
module quadrotor_motor_lag_mixer #(
   parameter int ROTOR_COUNT = qmlm_pkg::ROTOR_COUNT_DEF,
   localparam int REQ_BITS = ROTOR_COUNT * qmlm_pkg::SPEED_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = qmlm_pkg::THRUST_W + 2 * qmlm_pkg::TORQUE_W + qmlm_pkg::YAW_W
                           + ROTOR_COUNT * qmlm_pkg::SPEED_W + 1,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Item input. tdata: cmd_speed_0 .. cmd_speed_N, 18 bits each. tuser: mode.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [REQ_W-1:0]                    req_tdata,
   input  wire logic [qmlm_pkg::MODE_W-1:0]         req_tuser,
   // Result. tdata: thrust_total, roll_torque, pitch_torque, yaw_torque,
   // rotor_rate_0 .. rotor_rate_N, command_fresh, zero fill.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [RSP_W-1:0]                    rsp_tdata,
   // Register writes.
   input  wire logic                                csr_we,
   input  wire logic [qmlm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [qmlm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   qmlm_pkg::state_type state_ff, state_in;

   logic [qmlm_pkg::GAIN_W-1:0]  lag_gain_ff, arm_gain_ff, yaw_gain_ff;
   logic [qmlm_pkg::AGE_W-1:0]   timeout_ff;
   logic [qmlm_pkg::COEFF_W-1:0] coeff_ff;

   logic                       pending_ff, pending_in;
   logic                       seen_ff, seen_in;
   logic [qmlm_pkg::AGE_W-1:0] age_ff, age_in;
   logic                       fresh_ff, fresh_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   logic req_accept, is_cmd, is_tick, is_reset, load_out;
   qmlm_pkg::lane_ctl_type lane_ctl;
   qmlm_pkg::mix_ctl_type  mix_ctl;

   logic [ROTOR_COUNT-1:0][qmlm_pkg::SPEED_W-1:0] speed;
   logic [ROTOR_COUNT-1:0][qmlm_pkg::FORCE_W-1:0] thrust;
   logic [qmlm_pkg::THRUST_W-1:0] thrust_total;
   logic [qmlm_pkg::TORQUE_W-1:0] roll_torque, pitch_torque;
   logic [qmlm_pkg::YAW_W-1:0]    yaw_torque;

   assign req_accept = req_tvalid && req_tready;
   assign is_cmd     = req_tuser == qmlm_pkg::MODE_CMD;
   assign is_tick    = req_tuser == qmlm_pkg::MODE_TICK;
   assign is_reset   = req_tuser == qmlm_pkg::MODE_RESET;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qmlm_pkg::ST_IDLE:    if (req_accept && is_tick) state_in = qmlm_pkg::ST_LAG;
         qmlm_pkg::ST_LAG:     state_in = qmlm_pkg::ST_SPEED;
         qmlm_pkg::ST_SPEED:   state_in = qmlm_pkg::ST_SQUARE;
         qmlm_pkg::ST_SQUARE:  state_in = qmlm_pkg::ST_PROD_LO;
         qmlm_pkg::ST_PROD_LO: state_in = qmlm_pkg::ST_PROD_HI;
         qmlm_pkg::ST_PROD_HI: state_in = qmlm_pkg::ST_THRUST;
         qmlm_pkg::ST_THRUST:  state_in = qmlm_pkg::ST_MIX;
         qmlm_pkg::ST_MIX:     state_in = qmlm_pkg::ST_SCALE;
         qmlm_pkg::ST_SCALE:   state_in = qmlm_pkg::ST_OUT;
         qmlm_pkg::ST_OUT:     if (!rsp_valid_ff || rsp_tready) state_in = qmlm_pkg::ST_IDLE;
         default:              state_in = qmlm_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready         = state_ff == qmlm_pkg::ST_IDLE;
      lane_ctl           = '0;
      lane_ctl.fresh     = fresh_ff;
      lane_ctl.load_cmd  = req_accept && is_cmd;
      lane_ctl.clear     = req_accept && is_reset;
      lane_ctl.lag_en    = state_ff == qmlm_pkg::ST_LAG;
      lane_ctl.speed_en  = state_ff == qmlm_pkg::ST_SPEED;
      lane_ctl.square_en = state_ff == qmlm_pkg::ST_SQUARE;
      lane_ctl.lo_en     = state_ff == qmlm_pkg::ST_PROD_LO;
      lane_ctl.hi_en     = state_ff == qmlm_pkg::ST_PROD_HI;
      lane_ctl.thrust_en = state_ff == qmlm_pkg::ST_THRUST;
      mix_ctl.mix_en     = state_ff == qmlm_pkg::ST_MIX;
      mix_ctl.scale_en   = state_ff == qmlm_pkg::ST_SCALE;
      load_out           = (state_ff == qmlm_pkg::ST_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // Command aging. A tick consumes a pending command and restarts its age.
   always_comb begin
      pending_in = pending_ff;
      seen_in    = seen_ff;
      age_in     = age_ff;
      fresh_in   = fresh_ff;
      if (req_accept) begin
         if (is_cmd) begin
            pending_in = 1'b1;
         end else if (is_reset) begin
            pending_in = 1'b0;
            seen_in    = 1'b0;
            age_in     = '0;
         end else if (is_tick) begin
            if (pending_ff) begin
               pending_in = 1'b0;
               seen_in    = 1'b1;
               age_in     = '0;
            end else if (seen_ff && age_ff != qmlm_pkg::AGE_MAX) begin
               age_in = age_ff + 1'b1;
            end
            fresh_in = seen_in && (age_in <= timeout_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_data_in = RSP_W'({fresh_ff, speed, yaw_torque, pitch_torque, roll_torque,
                                thrust_total});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qmlm_pkg::ST_IDLE;
         pending_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         age_ff       <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         seen_ff      <= seen_in;
         age_ff       <= age_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_gain_ff <= qmlm_pkg::LAG_GAIN_RST;
         timeout_ff  <= qmlm_pkg::TIMEOUT_RST;
         coeff_ff    <= qmlm_pkg::THRUST_COEFF_RST;
         arm_gain_ff <= qmlm_pkg::ARM_GAIN_RST;
         yaw_gain_ff <= qmlm_pkg::YAW_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            qmlm_pkg::CSR_LAG_GAIN:     lag_gain_ff <= csr_wdata[qmlm_pkg::GAIN_W-1:0];
            qmlm_pkg::CSR_TIMEOUT:      timeout_ff  <= csr_wdata[qmlm_pkg::AGE_W-1:0];
            qmlm_pkg::CSR_THRUST_COEFF: coeff_ff    <= csr_wdata[qmlm_pkg::COEFF_W-1:0];
            qmlm_pkg::CSR_ARM_GAIN:     arm_gain_ff <= csr_wdata[qmlm_pkg::GAIN_W-1:0];
            qmlm_pkg::CSR_YAW_GAIN:     yaw_gain_ff <= csr_wdata[qmlm_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < ROTOR_COUNT; i++) begin : g_lane
      qmlm_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (lane_ctl),
         .cmd_speed    (req_tdata[i*qmlm_pkg::SPEED_W +: qmlm_pkg::SPEED_W]),
         .lag_gain     (lag_gain_ff),
         .thrust_coeff (coeff_ff),
         .speed        (speed[i]),
         .thrust       (thrust[i])
      );
   end

   qmlm_mix #(
      .ROTOR_COUNT (ROTOR_COUNT)
   ) u_mix (
      .clock        (clock),
      .ctl          (mix_ctl),
      .thrust       (thrust),
      .arm_gain     (arm_gain_ff),
      .yaw_gain     (yaw_gain_ff),
      .thrust_total (thrust_total),
      .roll_torque  (roll_torque),
      .pitch_torque (pitch_torque),
      .yaw_torque   (yaw_torque)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == qmlm_pkg::ST_OUT))
      else $error("result raised outside the output step");

   a_tick_starts_lanes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_tick) |=> (state_ff == qmlm_pkg::ST_LAG))
      else $error("accepted tick did not start the lanes");

   a_cmd_pending: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_cmd) |=> pending_ff)
      else $error("command item left no pending command");

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quadrotor_motor_lag_mixer: command, tick and reset items
// with random handshake gaps, checked against an in-bench model of the rotor lag and mixer.
// Depends on qmlm_pkg and the RTL of the mixer.
module tb;
   localparam int REQ_W = 4 * qmlm_pkg::SPEED_W;
   localparam int RSP_W = 152;
   localparam logic [qmlm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam longint CYCLE_LIMIT = 4_000_000;
   // Enough ticks after one command to outlast the short timeout by far.
   localparam int STALE_TICKS = 40;
   localparam int DRAIN_CYCLES = 12;
   localparam int PRINT_MAX = 40;

   typedef logic [3:0][qmlm_pkg::SPEED_W-1:0] speed_set_type;

   typedef struct packed {
      logic [2:0]                        fill;
      logic                              fresh;
      logic [3:0][qmlm_pkg::SPEED_W-1:0] rotor_rate;
      logic [qmlm_pkg::YAW_W-1:0]        yaw;
      logic [qmlm_pkg::TORQUE_W-1:0]     pitch;
      logic [qmlm_pkg::TORQUE_W-1:0]     roll;
      logic [qmlm_pkg::THRUST_W-1:0]     thrust;
   } mixer_out_type;

   class scoreboard_type;
      longint lag_gain, timeout_ticks, thrust_coeff, arm_gain, yaw_gain;
      longint demand[4];
      longint speed[4];
      bit pending_cmd, seen_cmd;
      longint age;
      mixer_out_type expected_q[$];
      int errors;

      function new();
         lag_gain = longint'(qmlm_pkg::LAG_GAIN_RST);
         timeout_ticks = longint'(qmlm_pkg::TIMEOUT_RST);
         thrust_coeff = longint'(qmlm_pkg::THRUST_COEFF_RST);
         arm_gain = longint'(qmlm_pkg::ARM_GAIN_RST);
         yaw_gain = longint'(qmlm_pkg::YAW_GAIN_RST);
         errors = 0;
         clear_rotors();
      endfunction

      function void clear_rotors();
         for (int i = 0; i < 4; i++) begin
            demand[i] = 0;
            speed[i] = 0;
         end
         pending_cmd = 0;
         seen_cmd = 0;
         age = 0;
      endfunction

      function void write_reg(logic [qmlm_pkg::CSR_IDX_W-1:0] idx, longint val);
         case (idx)
            qmlm_pkg::CSR_LAG_GAIN:     lag_gain = val;
            qmlm_pkg::CSR_TIMEOUT:      timeout_ticks = val;
            qmlm_pkg::CSR_THRUST_COEFF: thrust_coeff = val;
            qmlm_pkg::CSR_ARM_GAIN:     arm_gain = val;
            qmlm_pkg::CSR_YAW_GAIN:     yaw_gain = val;
            default: ;
         endcase
      endfunction

      static function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_item(logic [qmlm_pkg::MODE_W-1:0] mode, speed_set_type cmd);
         bit fresh;
         longint f[4];
         longint target;
         longint s;
         mixer_out_type r;
         case (mode)
            qmlm_pkg::MODE_CMD: begin
               for (int i = 0; i < 4; i++)
                  demand[i] = longint'((cmd[i] > qmlm_pkg::SPEED_MAX) ?
                                       qmlm_pkg::SPEED_MAX : cmd[i]);
               pending_cmd = 1;
            end
            qmlm_pkg::MODE_RESET: clear_rotors();
            qmlm_pkg::MODE_TICK: begin
               if (pending_cmd) begin
                  age = 0;
                  pending_cmd = 0;
                  seen_cmd = 1;
               end else if (seen_cmd && age < longint'(qmlm_pkg::AGE_MAX)) begin
                  age++;
               end
               fresh = seen_cmd && (age <= timeout_ticks);
               r = '0;
               for (int i = 0; i < 4; i++) begin
                  target = fresh ? demand[i] : 0;
                  // Arithmetic shift of a signed product floors toward minus infinity.
                  s = clip(speed[i] + ((lag_gain * (target - speed[i])) >>> 16), 0,
                           longint'(qmlm_pkg::SPEED_MAX));
                  speed[i] = s;
                  f[i] = (s * s * thrust_coeff) >> 32;
                  r.rotor_rate[i] = qmlm_pkg::SPEED_W'(s);
               end
               r.thrust = qmlm_pkg::THRUST_W'(clip(f[0] + f[1] + f[2] + f[3], 0,
                                                   longint'(qmlm_pkg::THRUST_MAX)));
               r.roll = qmlm_pkg::TORQUE_W'(clip((arm_gain * (f[0] - f[1] - f[2] + f[3])) >>> 16,
                                                 -262144, 262143));
               r.pitch = qmlm_pkg::TORQUE_W'(clip((arm_gain * (f[0] + f[1] - f[2] - f[3])) >>> 16,
                                                  -262144, 262143));
               r.yaw = qmlm_pkg::YAW_W'(clip((yaw_gain * (-f[0] + f[1] - f[2] + f[3])) >>> 16,
                                             -32768, 32767));
               r.fresh = fresh;
               expected_q.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= PRINT_MAX)
               $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(mixer_out_type got);
         mixer_out_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= PRINT_MAX)
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = expected_q.pop_front();
         field_check("thrust_total", 32'(want.thrust), 32'(got.thrust));
         field_check("roll_torque", 32'(want.roll), 32'(got.roll));
         field_check("pitch_torque", 32'(want.pitch), 32'(got.pitch));
         field_check("yaw_torque", 32'(want.yaw), 32'(got.yaw));
         for (int i = 0; i < 4; i++)
            field_check($sformatf("rotor_rate_%0d", i), 32'(want.rotor_rate[i]),
                        32'(got.rotor_rate[i]));
         field_check("command_fresh", 32'(want.fresh), 32'(got.fresh));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata = '0;
   logic [qmlm_pkg::MODE_W-1:0]     req_tuser = qmlm_pkg::MODE_CMD;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [RSP_W-1:0]                rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [qmlm_pkg::CSR_IDX_W-1:0]  csr_index = qmlm_pkg::CSR_LAG_GAIN;
   logic [qmlm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   scoreboard_type sb;
   longint cycles = 0;
   bit steady = 1'b0;    // both sides run without gaps
   bit req_run = 1'b0;   // sender stretch without gaps
   bit rsp_run = 1'b0;   // receiver stretch without stalls

   quadrotor_motor_lag_mixer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(logic [qmlm_pkg::MODE_W-1:0] mode, speed_set_type cmd);
      int gap;
      gap = (steady || req_run) ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, cmd);
   endtask

   task automatic hold_until_drained(int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic program_regs(int unsigned lag, int unsigned tmo, int unsigned coeff,
                               int unsigned arm, int unsigned yaw);
      logic [qmlm_pkg::CSR_IDX_W-1:0] idx[5];
      int unsigned val[5];
      idx = '{qmlm_pkg::CSR_LAG_GAIN, qmlm_pkg::CSR_TIMEOUT, qmlm_pkg::CSR_THRUST_COEFF,
              qmlm_pkg::CSR_ARM_GAIN, qmlm_pkg::CSR_YAW_GAIN};
      val = '{lag, tmo, coeff, arm, yaw};
      csr_we <= 1'b1;
      for (int k = 0; k < 5; k++) begin
         csr_index <= idx[k];
         csr_wdata <= qmlm_pkg::CSR_DATA_W'(val[k]);
         @(posedge clock);
         sb.write_reg(idx[k], longint'(val[k]));
      end
      csr_we <= 1'b0;
   endtask

   function automatic speed_set_type random_speeds();
      speed_set_type cmd;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 5))
            0:       cmd[i] = qmlm_pkg::SPEED_W'($urandom_range(0, 262143));
            1:       cmd[i] = qmlm_pkg::SPEED_W'($urandom_range(220000, 262143));
            2:       cmd[i] = '0;
            default: cmd[i] = qmlm_pkg::SPEED_W'($urandom_range(0, 230400));
         endcase
      end
      return cmd;
   endfunction

   function automatic int unsigned pick_level(int unsigned top);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   // Mostly a command followed by a run of ticks; the rest single items of any kind.
   task automatic run_random(int target);
      int done;
      done = 0;
      while (done < target) begin
         if ($urandom_range(0, 49) == 0)
            hold_until_drained(0);
         if ($urandom_range(0, 19) == 0)
            req_run = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 4) != 0) begin
            send_item(qmlm_pkg::MODE_CMD, random_speeds());
            done++;
            repeat ($urandom_range(1, 8)) begin
               send_item(qmlm_pkg::MODE_TICK, random_speeds());
               done++;
            end
         end else begin
            case ($urandom_range(0, 3))
               0: begin send_item(qmlm_pkg::MODE_CMD, random_speeds()); done++; end
               1: begin send_item(qmlm_pkg::MODE_TICK, random_speeds()); done++; end
               2: begin send_item(qmlm_pkg::MODE_RESET, random_speeds()); done++; end
               default: send_item(MODE_UNUSED, random_speeds());
            endcase
         end
      end
   endtask

   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = (steady || rsp_run) ? 0 : int'($urandom_range(0, 11));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(mixer_out_type'(rsp_tdata));
         if ($urandom_range(0, 39) == 0)
            rsp_run = !rsp_run;
      end
   end

   initial begin
      int unsigned tmo;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default registers: tick before any command, saturation of requests,
      // the unused mode and a reset item.
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({18'd0, 18'd230401, qmlm_pkg::SPEED_MAX, 18'h3FFFF}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_TICK, '1);
      send_item(MODE_UNUSED, '1);
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({18'd131072, 18'd230399, 18'd1, 18'd0}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_RESET, '1);
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({qmlm_pkg::SPEED_MAX, qmlm_pkg::SPEED_MAX,
                                 qmlm_pkg::SPEED_MAX, qmlm_pkg::SPEED_MAX}));
      send_item(qmlm_pkg::MODE_TICK, '0);

      // Largest gains and zero timeout: each torque and the total saturate for some of
      // the commands, and the second tick after a command is already stale.
      hold_until_drained(DRAIN_CYCLES);
      program_regs(32'hFFFF, 0, 32'hFFFFF, 32'hFFFF, 32'hFFFF);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({qmlm_pkg::SPEED_MAX, 18'd0, 18'd0, qmlm_pkg::SPEED_MAX}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({18'd0, qmlm_pkg::SPEED_MAX, qmlm_pkg::SPEED_MAX, 18'd0}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({18'd0, 18'd0, qmlm_pkg::SPEED_MAX, qmlm_pkg::SPEED_MAX}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({qmlm_pkg::SPEED_MAX, qmlm_pkg::SPEED_MAX, 18'd0, 18'd0}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({qmlm_pkg::SPEED_MAX, 18'd0, qmlm_pkg::SPEED_MAX, 18'd0}));
      send_item(qmlm_pkg::MODE_TICK, '0);
      send_item(qmlm_pkg::MODE_CMD,
                speed_set_type'({18'd0, qmlm_pkg::SPEED_MAX, 18'd0, qmlm_pkg::SPEED_MAX}));
      send_item(qmlm_pkg::MODE_TICK, '0);

      hold_until_drained(DRAIN_CYCLES);
      program_regs(0, 0, 0, 0, 0);
      send_item(qmlm_pkg::MODE_CMD, random_speeds());
      send_item(qmlm_pkg::MODE_TICK, '0);

      // A run of ticks after one command with a short timeout: the command goes
      // stale partway through and the rotors spin down.
      hold_until_drained(DRAIN_CYCLES);
      program_regs(32'(qmlm_pkg::LAG_GAIN_RST), 10, 32'(qmlm_pkg::THRUST_COEFF_RST),
                   32'(qmlm_pkg::ARM_GAIN_RST), 32'(qmlm_pkg::YAW_GAIN_RST));
      steady = 1'b1;
      send_item(qmlm_pkg::MODE_CMD, random_speeds());
      repeat (STALE_TICKS) send_item(qmlm_pkg::MODE_TICK, random_speeds());
      steady = 1'b0;

      repeat (5) begin
         hold_until_drained(DRAIN_CYCLES);
         case ($urandom_range(0, 3))
            0:       tmo = 0;
            1:       tmo = 32'hFFFF;
            2:       tmo = $urandom_range(1, 30);
            default: tmo = $urandom_range(0, 65535);
         endcase
         program_regs(pick_level(32'hFFFF), tmo, pick_level(32'hFFFFF),
                      pick_level(32'hFFFF), pick_level(32'hFFFF));
         run_random(125);
      end

      hold_until_drained(2 * DRAIN_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

>>> sim.f
sv/qmlm_pkg.sv
sv/qmlm_lane.sv
sv/qmlm_mix.sv
sv/quadrotor_motor_lag_mixer.sv
sim/tb.sv
